// ===== rtl/core/egcd_pkg.sv =====
// Shared constants and types for the extended gcd block.
package egcd_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int SHIFT_W = $clog2(DATA_WIDTH);
	localparam logic [SHIFT_W-1:0] SHIFT_TOP = SHIFT_W'(DATA_WIDTH - 1);

	typedef struct packed {
		logic [DATA_WIDTH-1:0] rem;
		logic [DATA_WIDTH-1:0] coef_big;
		logic [DATA_WIDTH-1:0] coef_small;
	} egcd_row_t;
endpackage

// ===== rtl/core/egcd_step.sv =====
// Shared shift-subtract unit: one quotient bit of row reduction per cycle.
module egcd_step (
	input  egcd_pkg::egcd_row_t          row_num,
	input  egcd_pkg::egcd_row_t          row_den,
	input  logic [egcd_pkg::SHIFT_W-1:0] shift,
	output egcd_pkg::egcd_row_t          row_out
);
	logic take;

	assign take = (row_num.rem >> shift) >= row_den.rem;

	always_comb begin
		row_out = row_num;
		if (take) begin
			row_out.rem        = row_num.rem - (row_den.rem << shift);
			row_out.coef_big   = row_num.coef_big - (row_den.coef_big << shift);
			row_out.coef_small = row_num.coef_small - (row_den.coef_small << shift);
		end
	end
endmodule

// ===== rtl/core/extended_gcd_cofactors.sv =====
// Top level: sequencer around the shared shift-subtract unit.
// Timing: when either operand is zero, done rises in the cycle after start; else
//   Euclid remainder steps run through the one-bit-per-cycle subtract unit.
// Throughput: one item at a time; start is taken only while busy is low.
// Result: done is high for one cycle with the outputs; the receiver cannot stall.
// Reset: arst_n clears the sequencer and done; payload registers are not reset.
module extended_gcd_cofactors (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [egcd_pkg::DATA_WIDTH-1:0] operand_a,
	input  logic signed [egcd_pkg::DATA_WIDTH-1:0] operand_b,
	output logic                                done,
	output logic [egcd_pkg::DATA_WIDTH-1:0]     gcd_value,
	output logic signed [egcd_pkg::DATA_WIDTH-1:0] cofactor_a,
	output logic signed [egcd_pkg::DATA_WIDTH-1:0] cofactor_b,
	output logic                                both_zero_error
);
	localparam int W = egcd_pkg::DATA_WIDTH;
	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                         state_q;
	egcd_pkg::egcd_row_t          r0_q, r1_q, r0_next;
	logic [egcd_pkg::SHIFT_W-1:0] shift_q;
	logic                         neg_a_q, neg_b_q, swap_q, done_q;
	logic [W-1:0]                 gcd_q, ca_q, cb_q;
	logic                         err_q;
	logic                         na, nb;
	logic [W-1:0]                 ua, ub;

	assign na = operand_a[W-1];
	assign nb = operand_b[W-1];
	assign ua = na ? (W'(0) - operand_a) : operand_a;
	assign ub = nb ? (W'(0) - operand_b) : operand_b;

	egcd_step u_step (
		.row_num(r0_q),
		.row_den(r1_q),
		.shift  (shift_q),
		.row_out(r0_next)
	);

	function automatic logic [3*W-1:0] finish(egcd_pkg::egcd_row_t r, logic sw,
			logic nga, logic ngb);
		logic [W-1:0] a, b;
		a = sw ? r.coef_small : r.coef_big;
		b = sw ? r.coef_big : r.coef_small;
		if (nga) a = W'(0) - a;
		if (ngb) b = W'(0) - b;
		return {r.rem, a, b};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						neg_a_q <= na;
						neg_b_q <= nb;
						swap_q  <= ua < ub;
						shift_q <= egcd_pkg::SHIFT_TOP;
						if (ua == '0 && ub == '0) begin
							done_q <= 1'b1;
							err_q  <= 1'b1;
							gcd_q  <= '0;
							ca_q   <= '0;
							cb_q   <= '0;
						end else if (ua == '0 || ub == '0) begin
							done_q <= 1'b1;
							err_q  <= 1'b0;
							gcd_q  <= (ua == '0) ? ub : ua;
							ca_q   <= (ua == '0) ? '0 : (na ? '1 : W'(1));
							cb_q   <= (ub == '0) ? '0 : (nb ? '1 : W'(1));
						end else begin
							r0_q    <= '{rem: (ua < ub) ? ub : ua, coef_big: W'(1),
								coef_small: '0};
							r1_q    <= '{rem: (ua < ub) ? ua : ub, coef_big: '0,
								coef_small: W'(1)};
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (shift_q != '0) begin
						r0_q    <= r0_next;
						shift_q <= shift_q - 1'b1;
					end else if (r0_next.rem == '0) begin
						{gcd_q, ca_q, cb_q} <= finish(r1_q, swap_q, neg_a_q, neg_b_q);
						err_q   <= 1'b0;
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						r0_q    <= r1_q;
						r1_q    <= r0_next;
						shift_q <= egcd_pkg::SHIFT_TOP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy            = state_q != ST_IDLE;
	assign done            = done_q;
	assign gcd_value       = gcd_q;
	assign cofactor_a      = ca_q;
	assign cofactor_b      = cb_q;
	assign both_zero_error = err_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> r1_q.rem != '0) else $error("zero divisor");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && both_zero_error |-> gcd_value == '0 && cofactor_a == '0)
		else $error("error result not zero");
	a_gcd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !both_zero_error |-> gcd_value != '0) else $error("zero gcd");
endmodule
